/* src/plim_pkg.sv */
package plim_pkg;

	// Field widths fixed by the item format
	localparam int IDX_BITS = 6;
	localparam int CFG_DATA_BITS = 7;
	localparam int CFG_INDEX_BITS = 1;

	// Item kinds carried in the slave tuser bit
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Register indexes of the configuration port
	localparam logic [CFG_INDEX_BITS-1:0] REG_POINTS_IN_USE = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CLAMP         = 1'd1;

	// Status of the shared adder
	typedef struct packed {
		logic neg;
		logic zero;
	} plim_flags_t;

endpackage

/* src/plim_alu.sv */
module plim_alu import plim_pkg::*; #(
	parameter int W = 34
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] res,
	output plim_flags_t  flags
);

	// One adder serves compares, differences, multiply steps, divide steps and the final sum
	assign res = sub ? (a - b) : (a + b);

	always_comb begin
		flags.neg  = res[W-1];
		flags.zero = (res == '0);
	end

endmodule

/* src/plim_table.sv */
module plim_table #(
	parameter int DEPTH = 64,
	parameter int W = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wx,
	input  logic [W-1:0]             wy,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rx,
	output logic [W-1:0]             ry
);

	logic [W-1:0] mem_x [DEPTH];
	logic [W-1:0] mem_y [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_x[waddr] <= wx;
			mem_y[waddr] <= wy;
		end
	end

	// Registered read: data appears the cycle after the address
	always_ff @(posedge clk) begin
		rx <= mem_x[raddr];
		ry <= mem_y[raddr];
	end

endmodule

/* src/piecewise_linear_interpolator_unit.sv */
// Piecewise linear interpolator over a breakpoint table.
// Slave stream: tuser is the item kind (0 load, 1 query); tdata holds, from bit 0 up,
// entry_index (6 bits), x_value and y_value (VALUE_BITS each, signed), padded to bytes.
// A load writes one breakpoint in its accept cycle and gives no beat; s_tready
// stays high. A query returns one master beat: tdata holds y_result
// (signed, padded to bytes), tuser holds out_of_range.
// A query outside the table or equal to the first x finishes without a scan; any other
// query scans for its segment, then forms dx, the span and dy, negating dy when y falls
// across the segment, and then multiplies, divides and sums.
// Inside a query a single adder does every compare and difference, the table is
// scanned one entry a cycle through its one read port, then the product is built by
// shift and add and divided by restoring steps, one bit a cycle each.
// The final sum saturates to the signed value range.
// Only one item is in work at a time; s_tready is high only when the sequencer idles.
// The output register holds a finished beat while the receiver stalls, the next query
// may still be accepted, and its result waits in the sequencer until the register frees.
// Reset clears the sequencer, the output valid and the registers (points_in_use 2,
// clamp off); the table keeps its contents and must be loaded before it is queried.
// Fixed point position does not enter the arithmetic, so it is not a parameter.
module piecewise_linear_interpolator_unit import plim_pkg::*; #(
	parameter int MAX_POINTS = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	// Configuration write port
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	// Slave stream
	input  logic s_tvalid,
	output logic s_tready,
	// tdata: entry_index, x_value, y_value, zero pad
	input  logic [((IDX_BITS + 2*VALUE_BITS + 7)/8)*8-1:0] s_tdata,
	// tuser: mode
	input  logic s_tuser,
	// Master stream
	output logic m_tvalid,
	input  logic m_tready,
	// tdata: y_result, zero pad
	output logic [((VALUE_BITS + 7)/8)*8-1:0] m_tdata,
	// tuser: out_of_range
	output logic m_tuser
);

	localparam int VB   = VALUE_BITS;
	localparam int AB   = $clog2(MAX_POINTS);
	localparam int AW   = VALUE_BITS + 2;
	localparam int CW   = $clog2(VALUE_BITS);
	localparam int M_DW = ((VALUE_BITS + 7)/8)*8;

	// Sequencer codes
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_RD_LAST  = 4'd1;
	localparam logic [3:0] ST_CHK_LAST = 4'd2;
	localparam logic [3:0] ST_SCAN     = 4'd3;
	localparam logic [3:0] ST_DX       = 4'd4;
	localparam logic [3:0] ST_SPAN     = 4'd5;
	localparam logic [3:0] ST_DY       = 4'd6;
	localparam logic [3:0] ST_DYN      = 4'd7;
	localparam logic [3:0] ST_MUL      = 4'd8;
	localparam logic [3:0] ST_DIV      = 4'd9;
	localparam logic [3:0] ST_SUM      = 4'd10;
	localparam logic [3:0] ST_FINISH   = 4'd11;

	// Configuration registers
	logic [CFG_DATA_BITS-1:0] pts_q;
	logic                     clamp_q;

	// Sequencer and datapath
	logic [3:0]      state_q;
	logic [VB-1:0]   x_q;       // query abscissa
	logic [VB-1:0]   xa_q;      // left breakpoint x
	logic [VB-1:0]   ya_q;      // left breakpoint y
	logic [VB-1:0]   xb_q;      // right breakpoint x
	logic [VB-1:0]   yb_q;      // right breakpoint y
	logic [VB-1:0]   span_q;    // x2 - x1, always positive here
	logic [VB-1:0]   mcand_q;   // |y2 - y1|
	logic [2*VB-1:0] p_q;       // product, then remainder and quotient
	logic            neg_q;     // y falls across the segment
	logic [CW-1:0]   cnt_q;
	logic [AB-1:0]   scan_q;    // index of the entry arriving from the table
	logic [AB-1:0]   last_q;    // index of the last breakpoint in use
	logic            lt0_q;     // query below the first x
	logic            eq0_q;     // query equal to the first x
	logic [VB-1:0]   res_y_q;
	logic            res_oor_q;

	// Output register
	logic            m_valid_q;
	logic [VB-1:0]   m_y_q;
	logic            m_oor_q;

	// Slave fields
	logic [IDX_BITS-1:0] s_idx;
	logic [VB-1:0]       s_x;
	logic [VB-1:0]       s_y;
	logic                s_acc;

	// Table ports
	logic                   tbl_we;
	logic [AB-1:0]          widx;
	logic [AB-1:0]          raddr;
	logic [VB-1:0]          rd_x;
	logic [VB-1:0]          rd_y;
	logic [AB-1:0]          last_d;

	// Shared adder
	logic [AW-1:0] alu_a;
	logic [AW-1:0] alu_b;
	logic          alu_sub;
	logic [AW-1:0] alu_res;
	plim_flags_t   alu_flags;

	logic          out_load;
	logic [VB-1:0] rem_n;
	logic [VB-1:0] sum_sat;

	assign s_idx = s_tdata[IDX_BITS-1:0];
	assign s_x   = s_tdata[IDX_BITS +: VB];
	assign s_y   = s_tdata[IDX_BITS+VB +: VB];

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// Drop loads whose index lies beyond the table
	assign widx   = AB'(s_idx);
	assign tbl_we = s_acc && (s_tuser == MODE_LOAD) && (int'(s_idx) < MAX_POINTS);

	// Clamp the searched length into two .. MAX_POINTS
	always_comb begin
		if (pts_q < 7'd2) begin
			last_d = AB'(1);
		end else if (int'(pts_q) > MAX_POINTS) begin
			last_d = AB'(MAX_POINTS - 1);
		end else begin
			last_d = AB'(pts_q - 7'd1);
		end
	end

	// Read address: first entry, then last, then a running scan one entry ahead
	always_comb begin
		case (state_q)
			ST_RD_LAST:  raddr = last_q;
			ST_CHK_LAST: raddr = AB'(1);
			ST_SCAN:     raddr = scan_q + AB'(1);
			default:     raddr = '0;
		endcase
	end

	plim_table #(
		.DEPTH(MAX_POINTS),
		.W(VB)
	) u_table (
		.clk(clk),
		.we(tbl_we),
		.waddr(widx),
		.wx(s_x),
		.wy(s_y),
		.raddr(raddr),
		.rx(rd_x),
		.ry(rd_y)
	);

	// Route operands to the adder for each step
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b1;
		case (state_q)
			ST_RD_LAST: begin
				alu_a = {{2{x_q[VB-1]}}, x_q};
				alu_b = {{2{rd_x[VB-1]}}, rd_x};
			end
			ST_CHK_LAST, ST_SCAN: begin
				alu_a = {{2{rd_x[VB-1]}}, rd_x};
				alu_b = {{2{x_q[VB-1]}}, x_q};
			end
			ST_DX: begin
				alu_a = {{2{x_q[VB-1]}}, x_q};
				alu_b = {{2{xa_q[VB-1]}}, xa_q};
			end
			ST_SPAN: begin
				alu_a = {{2{xb_q[VB-1]}}, xb_q};
				alu_b = {{2{xa_q[VB-1]}}, xa_q};
			end
			ST_DY: begin
				alu_a = {{2{yb_q[VB-1]}}, yb_q};
				alu_b = {{2{ya_q[VB-1]}}, ya_q};
			end
			ST_DYN: begin
				alu_a = {{2{ya_q[VB-1]}}, ya_q};
				alu_b = {{2{yb_q[VB-1]}}, yb_q};
			end
			ST_MUL: begin
				alu_sub = 1'b0;
				alu_a   = {2'b0, p_q[2*VB-1:VB]};
				alu_b   = p_q[0] ? {2'b0, mcand_q} : '0;
			end
			ST_DIV: begin
				alu_a = {1'b0, p_q[2*VB-1:VB], p_q[VB-1]};
				alu_b = {2'b0, span_q};
			end
			ST_SUM: begin
				alu_sub = neg_q;
				alu_a   = {{2{ya_q[VB-1]}}, ya_q};
				alu_b   = {2'b0, p_q[VB-1:0]};
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	plim_alu #(
		.W(AW)
	) u_alu (
		.a(alu_a),
		.b(alu_b),
		.sub(alu_sub),
		.res(alu_res),
		.flags(alu_flags)
	);

	// Restoring step: keep the shifted remainder when the subtraction goes negative
	assign rem_n = alu_flags.neg ? {p_q[2*VB-2:VB], p_q[VB-1]} : alu_res[VB-1:0];

	// Saturate the final sum: the top bits must all match the value sign bit
	always_comb begin
		if (alu_res[AW-1:VB-1] == '0 || alu_res[AW-1:VB-1] == '1) begin
			sum_sat = alu_res[VB-1:0];
		end else if (alu_res[AW-1]) begin
			sum_sat = {1'b1, {(VB-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(VB-1){1'b1}}};
		end
	end

	assign out_load = (state_q == ST_FINISH) && (!m_valid_q || m_tready);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q   <= 7'd2;
			clamp_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POINTS_IN_USE: pts_q   <= cfg_data;
				REG_CLAMP:         clamp_q <= cfg_data[0];
				default:           pts_q   <= pts_q;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc && (s_tuser == MODE_QUERY)) begin
						state_q <= ST_RD_LAST;
					end
				end
				ST_RD_LAST: state_q <= ST_CHK_LAST;
				ST_CHK_LAST: begin
					if (lt0_q || alu_flags.neg || eq0_q) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!alu_flags.neg) begin
						state_q <= ST_DX;
					end
				end
				ST_DX:   state_q <= ST_SPAN;
				ST_SPAN: state_q <= ST_DY;
				ST_DY:   state_q <= alu_flags.neg ? ST_DYN : ST_MUL;
				ST_DYN:  state_q <= ST_MUL;
				ST_MUL: begin
					if (cnt_q == '0) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					x_q    <= s_x;
					last_q <= last_d;
				end
			end
			ST_RD_LAST: begin
				// entry 0 arrives: hold it as the left end
				xa_q  <= rd_x;
				ya_q  <= rd_y;
				lt0_q <= alu_flags.neg;
				eq0_q <= alu_flags.zero;
			end
			ST_CHK_LAST: begin
				scan_q    <= AB'(1);
				res_oor_q <= lt0_q || alu_flags.neg;
				if (lt0_q || alu_flags.neg) begin
					if (!clamp_q) begin
						res_y_q <= '0;
					end else begin
						res_y_q <= lt0_q ? ya_q : rd_y;
					end
				end else begin
					res_y_q <= ya_q;
				end
			end
			ST_SCAN: begin
				if (!alu_flags.neg) begin
					xb_q <= rd_x;
					yb_q <= rd_y;
				end else begin
					// advance: this entry becomes the left end
					xa_q   <= rd_x;
					ya_q   <= rd_y;
					scan_q <= scan_q + AB'(1);
				end
			end
			ST_DX: p_q <= {{VB{1'b0}}, alu_res[VB-1:0]};
			ST_SPAN: span_q <= alu_res[VB-1:0];
			ST_DY: begin
				neg_q   <= alu_flags.neg;
				mcand_q <= alu_res[VB-1:0];
				cnt_q   <= CW'(VB - 1);
			end
			ST_DYN: mcand_q <= alu_res[VB-1:0];
			ST_MUL: begin
				p_q   <= {alu_res[VB:0], p_q[VB-1:1]};
				cnt_q <= (cnt_q == '0) ? CW'(VB - 1) : cnt_q - CW'(1);
			end
			ST_DIV: begin
				p_q   <= {rem_n, p_q[VB-2:0], ~alu_flags.neg};
				cnt_q <= cnt_q - CW'(1);
			end
			ST_SUM: begin
				res_y_q   <= sum_sat;
				res_oor_q <= 1'b0;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	// Output register: fill from the sequencer, drain on the master handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_y_q   <= res_y_q;
			m_oor_q <= res_oor_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_DW'(m_y_q);
	assign m_tuser  = m_oor_q;

	// The scan never runs past the last breakpoint checked at the start
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_q <= last_q))
		else $error("scan passed last breakpoint");

	// The remainder stays below the divisor, so the quotient fits the value width
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (p_q[2*VB-1:VB] < span_q))
		else $error("remainder not below span");

	// A bracketing segment always has positive width
	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (span_q != '0))
		else $error("zero span in multiply");

	// A finished result waits while the output register is full and stalled
	a_finish_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && m_valid_q && !m_tready) |=> (state_q == ST_FINISH))
		else $error("result left before output register freed");

endmodule
